// ----- src/spq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;

  // s_tdata: item_data, item_priority (48 bits, 6 bytes)
  localparam int S_TDATA_W = DATA_W + PRIO_W;
  // m_tdata: status, out_data, out_priority, zero filled to 7 bytes
  localparam int STAT_W    = 2;
  localparam int M_PAY_W   = STAT_W + DATA_W + PRIO_W;
  localparam int M_TDATA_W = ((M_PAY_W + 7) / 8) * 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage
`default_nettype wire

// ----- src/sorted_priority_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted-array priority queue: one entry RAM walked by a small sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | fields (lsb first)                     | accepted when
//  s       | in  | tuser: kind; tdata: data, priority     | s_tvalid & s_tready
//  m       | out | tdata: status, data, priority, zeros   | m_tvalid & m_tready
//
//  insert: walks from the tail, moving each entry of lower priority back one slot
//  remove: takes the head, then moves each later entry forward, one entry per cycle
//  insert into an empty queue, rejected insert or empty remove: no walk, straight to the result
//  the entry ram has one read and one write port; one entry moves per cycle
//  rst clears the count, the sequencer and m_tvalid; ram contents are kept
//  s_tready is low while an item is in work or its result waits for a free output: !m_tvalid or m_tready
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // item_data[31:0], item_priority[47:32]
  input  wire logic [0:0]           s_tuser,   // kind[0]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata    // status[1:0], out_data[33:2],
                                               // out_priority[49:34], zeros above
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_CMP  = 3'd1;
  localparam logic [2:0] S_REM_HEAD = 3'd2;
  localparam logic [2:0] S_REM_MOVE = 3'd3;
  localparam logic [2:0] S_FIN      = 3'd4;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  pos, pos_next;
  logic [DATA_W-1:0] new_data, new_data_next;
  logic [PRIO_W-1:0] new_prio, new_prio_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [DATA_W-1:0] res_data, res_data_next;
  logic [PRIO_W-1:0] res_prio, res_prio_next;
  logic [M_PAY_W-1:0] out_pay;

  entry_t            mem [DEPTH];
  entry_t            rd_q;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  entry_t            wr_entry;

  logic              accept, out_free, out_load;
  logic [CNT_W-1:0]  pos_m1, pos_m2, pos_p1;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == S_FIN) && out_free;
  assign pos_m1   = pos - CNT_W'(1);
  assign pos_m2   = pos - CNT_W'(2);
  assign pos_p1   = pos + CNT_W'(1);

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    new_data_next   = new_data;
    new_prio_next   = new_prio;
    res_status_next = res_status;
    res_data_next   = res_data;
    res_prio_next   = res_prio;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_entry        = '{data: new_data, prio: new_prio};

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          new_data_next   = s_tdata[DATA_W-1:0];
          new_prio_next   = s_tdata[S_TDATA_W-1:DATA_W];
          res_data_next   = '0;
          res_prio_next   = '0;
          res_status_next = STAT_DONE;
          if (s_tuser[0] == KIND_INSERT) begin
            if (count == CNT_W'(DEPTH)) begin
              res_status_next = STAT_FULL;
              state_next      = S_FIN;
            end else if (count == '0) begin
              wr_en      = 1'b1;
              wr_addr    = '0;
              wr_entry   = '{data: s_tdata[DATA_W-1:0],
                             prio: s_tdata[S_TDATA_W-1:DATA_W]};
              count_next = CNT_W'(1);
              state_next = S_FIN;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = ADDR_W'(count - CNT_W'(1));
              pos_next   = count;
              state_next = S_INS_CMP;
            end
          end else begin
            if (count == '0) begin
              res_status_next = STAT_EMPTY;
              state_next      = S_FIN;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              pos_next   = CNT_W'(1);
              state_next = S_REM_HEAD;
            end
          end
        end
      end

      // rd_q holds entry pos-1 while pos is nonzero; at pos zero the new entry goes in front
      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(pos);
        if (pos != '0 && new_prio > rd_q.prio) begin
          wr_entry = rd_q;
          pos_next = pos_m1;
          if (pos > CNT_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(pos_m2);
          end
        end else begin
          count_next = count + CNT_W'(1);
          state_next = S_FIN;
        end
      end

      S_REM_HEAD: begin
        res_data_next = rd_q.data;
        res_prio_next = rd_q.prio;
        if (count == CNT_W'(1)) begin
          count_next = '0;
          state_next = S_FIN;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = ADDR_W'(pos);
          state_next = S_REM_MOVE;
        end
      end

      // rd_q holds entry pos, moved forward to pos-1
      S_REM_MOVE: begin
        wr_en    = 1'b1;
        wr_addr  = ADDR_W'(pos_m1);
        wr_entry = rd_q;
        pos_next = pos_p1;
        if (pos_p1 < count) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(pos_p1);
        end else begin
          count_next = count - CNT_W'(1);
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    new_data   <= new_data_next;
    new_prio   <= new_prio_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    res_prio   <= res_prio_next;
    if (out_load) begin
      m_tdata <= M_TDATA_W'(out_pay);
    end
  end

  assign out_pay = {res_prio, res_data, res_status};

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CNT_W'(1) ||
                     count + CNT_W'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_CMP || state == S_REM_MOVE) |-> pos <= count)
    else $error("walk position outside the stored entries");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_status == STAT_FULL) |-> count == CNT_W'(DEPTH))
    else $error("full reported while space is left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_status == STAT_EMPTY) |-> count == '0)
    else $error("empty reported while entries are stored");
`endif

endmodule
`default_nettype wire
